// ===== rtl/pdsm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdsm_pkg
// Shared types and constants for the per-process sequence monitor.
// ----------------------------------------------------------------------------
package pdsm_pkg;

    localparam int SLOT_W   = 10;
    localparam int STATE_W  = 6;
    localparam int SYMBOL_W = 6;
    localparam int REC_W    = 8;
    localparam int CNT_W    = 11;

    localparam int PROCESS_SLOTS_DEF = 1024;
    localparam int STATE_COUNT_DEF   = 64;
    localparam int SYMBOL_COUNT_DEF  = 64;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PREAD,
        ST_TREAD,
        ST_DONE
    } mon_state_t;

    typedef enum logic [1:0] {
        VERDICT_ACCEPT      = 2'd0,
        VERDICT_NO_TRANS    = 2'd1,
        VERDICT_AFTER_FINAL = 2'd2,
        VERDICT_LOADED      = 2'd3
    } verdict_t;

endpackage

// ===== rtl/pdsm_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdsm_ram
// Simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module pdsm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/per_process_dfa_sequence_monitor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_process_dfa_sequence_monitor
// Table-driven automaton per process slot, with a shared transition table.
// ----------------------------------------------------------------------------
//  channel  | handshake        | payload
//  ---------+------------------+---------------------------------------------
//  input    | start / busy     | mode, process_slot, symbol, from_state,
//           |                  | to_state, to_final, entry_valid
//  result   | done (one cycle) | verdict, kill, old_state, new_state, new_final
//  config   | cfg_we           | cfg_data (start state)
//
//  A load word is taken on the accepting edge; done follows that edge.
//  An event word runs slot reduction, slot-table read, transition read,
//  write-back in that order, the reads chained through the two RAMs.
//  After reset both tables are zeroed, one address a cycle, with busy high
//  until the larger of the two tables, max(STATE_COUNT*SYMBOL_COUNT, PROCESS_SLOTS) deep, is cleared.
//  Results cannot be held off; done pulses for exactly one cycle.
// ----------------------------------------------------------------------------
module per_process_dfa_sequence_monitor
    import pdsm_pkg::*;
#(
    parameter int PROCESS_SLOTS = PROCESS_SLOTS_DEF,
    parameter int STATE_COUNT   = STATE_COUNT_DEF,
    parameter int SYMBOL_COUNT  = SYMBOL_COUNT_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                mode,
    input  logic [SLOT_W-1:0]   process_slot,
    input  logic [SYMBOL_W-1:0] symbol,
    input  logic [STATE_W-1:0]  from_state,
    input  logic [STATE_W-1:0]  to_state,
    input  logic                to_final,
    input  logic                entry_valid,
    input  logic                cfg_we,
    input  logic [STATE_W-1:0]  cfg_data,
    output logic                done,
    output logic [1:0]          verdict,
    output logic                kill,
    output logic [STATE_W-1:0]  old_state,
    output logic [STATE_W-1:0]  new_state,
    output logic                new_final
);

    localparam int TRANS_DEPTH = STATE_COUNT * SYMBOL_COUNT;
    localparam int TA_W        = $clog2(TRANS_DEPTH);
    localparam int PA_W        = $clog2(PROCESS_SLOTS);
    localparam int CLR_DEPTH   = (TRANS_DEPTH > PROCESS_SLOTS) ? TRANS_DEPTH : PROCESS_SLOTS;
    localparam int CLR_W       = $clog2(CLR_DEPTH);
    localparam int MOD_SHIFT   = SLOT_W + $clog2(PROCESS_SLOTS);
    localparam int MOD_MULT    = (2 ** MOD_SHIFT + PROCESS_SLOTS - 1) / PROCESS_SLOTS;
    localparam int MOD_PW      = MOD_SHIFT + SLOT_W + 2;

    function automatic logic [TA_W-1:0] tr_index(input logic [STATE_W-1:0]  st,
                                                 input logic [SYMBOL_W-1:0] sy);
        tr_index = TA_W'(TA_W'(st) * TA_W'(SYMBOL_COUNT) + TA_W'(sy));
    endfunction

    mon_state_t           state_reg, state_next;
    logic [CLR_W-1:0]     clr_cnt_reg, clr_cnt_next;
    logic [STATE_W-1:0]   start_state_reg;
    logic                 done_reg, done_next;

    logic [SLOT_W-1:0]    slot_reg;
    logic [SLOT_W-1:0]    q_reg;
    logic [PA_W-1:0]      idx_reg;
    logic [SYMBOL_W-1:0]  sym_reg;
    logic [STATE_W-1:0]   cur_reg;
    logic                 range_reg;
    logic                 after_final_reg;

    verdict_t             verdict_reg, verdict_next;
    logic                 kill_reg, kill_next;
    logic [STATE_W-1:0]   old_state_reg, old_state_next;
    logic [STATE_W-1:0]   new_state_reg, new_state_next;
    logic                 new_final_reg, new_final_next;

    logic                 accept;
    logic                 load_ok;
    logic [SLOT_W-1:0]    q_calc;
    logic [SLOT_W-1:0]    slot_diff;
    logic [PA_W-1:0]      idx_calc;
    logic [STATE_W-1:0]   cur_calc;
    logic                 after_final_calc;
    logic                 range_calc;

    logic                 t_we;
    logic [TA_W-1:0]      t_waddr;
    logic [REC_W-1:0]     t_wdata;
    logic [REC_W-1:0]     t_rdata;
    logic                 p_we;
    logic [PA_W-1:0]      p_waddr;
    logic [REC_W-1:0]     p_wdata;
    logic [REC_W-1:0]     p_rdata;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    assign load_ok = (CNT_W'(from_state) < CNT_W'(STATE_COUNT))
                  && (CNT_W'(symbol) < CNT_W'(SYMBOL_COUNT));

    assign q_calc    = SLOT_W'((MOD_PW'(process_slot) * MOD_PW'(MOD_MULT)) >> MOD_SHIFT);
    assign slot_diff = slot_reg - SLOT_W'(q_reg * SLOT_W'(PROCESS_SLOTS));
    assign idx_calc  = PA_W'(slot_diff);

    assign after_final_calc = p_rdata[7] && p_rdata[6];
    assign cur_calc         = p_rdata[7] ? p_rdata[STATE_W-1:0] : start_state_reg;
    assign range_calc       = (CNT_W'(cur_calc) < CNT_W'(STATE_COUNT))
                           && (CNT_W'(sym_reg) < CNT_W'(SYMBOL_COUNT));

    pdsm_ram #(
        .WIDTH (REC_W),
        .DEPTH (TRANS_DEPTH)
    ) u_trans_ram (
        .clk   (clk),
        .we    (t_we),
        .waddr (t_waddr),
        .wdata (t_wdata),
        .raddr (tr_index(cur_calc, sym_reg)),
        .rdata (t_rdata)
    );

    pdsm_ram #(
        .WIDTH (REC_W),
        .DEPTH (PROCESS_SLOTS)
    ) u_proc_ram (
        .clk   (clk),
        .we    (p_we),
        .waddr (p_waddr),
        .wdata (p_wdata),
        .raddr (idx_calc),
        .rdata (p_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        done_next      = 1'b0;
        verdict_next   = verdict_reg;
        kill_next      = kill_reg;
        old_state_next = old_state_reg;
        new_state_next = new_state_reg;
        new_final_next = new_final_reg;
        t_we           = 1'b0;
        t_waddr        = tr_index(from_state, symbol);
        t_wdata        = entry_valid ? {1'b1, to_final, to_state} : '0;
        p_we           = 1'b0;
        p_waddr        = idx_reg;
        p_wdata        = '0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                t_waddr      = clr_cnt_reg[TA_W-1:0];
                t_wdata      = '0;
                t_we         = ({1'b0, clr_cnt_reg} < (CLR_W+1)'(TRANS_DEPTH));
                p_waddr      = clr_cnt_reg[PA_W-1:0];
                p_we         = ({1'b0, clr_cnt_reg} < (CLR_W+1)'(PROCESS_SLOTS));
                if (clr_cnt_reg == CLR_W'(CLR_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (mode)
                    begin
                        t_we           = load_ok;
                        done_next      = 1'b1;
                        verdict_next   = VERDICT_LOADED;
                        kill_next      = 1'b0;
                        old_state_next = '0;
                        new_state_next = '0;
                        new_final_next = 1'b0;
                    end
                    else
                    begin
                        state_next = ST_PREAD;
                    end
                end
            end
            ST_PREAD:
            begin
                state_next = ST_TREAD;
            end
            ST_TREAD:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                state_next     = ST_IDLE;
                done_next      = 1'b1;
                p_we           = 1'b1;
                new_state_next = '0;
                new_final_next = 1'b0;
                if (after_final_reg)
                begin
                    verdict_next   = VERDICT_AFTER_FINAL;
                    kill_next      = 1'b1;
                    old_state_next = '0;
                end
                else if (!range_reg || !t_rdata[7])
                begin
                    verdict_next   = VERDICT_NO_TRANS;
                    kill_next      = 1'b1;
                    old_state_next = cur_reg;
                end
                else
                begin
                    verdict_next   = VERDICT_ACCEPT;
                    kill_next      = 1'b0;
                    old_state_next = cur_reg;
                    if (t_rdata[6])
                    begin
                        p_wdata        = {2'b11, {STATE_W{1'b0}}};
                        new_final_next = 1'b1;
                    end
                    else
                    begin
                        p_wdata        = {2'b10, t_rdata[STATE_W-1:0]};
                        new_state_next = t_rdata[STATE_W-1:0];
                    end
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            clr_cnt_reg     <= '0;
            done_reg        <= 1'b0;
            start_state_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            done_reg    <= done_next;
            if (cfg_we)
            begin
                start_state_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        verdict_reg   <= verdict_next;
        kill_reg      <= kill_next;
        old_state_reg <= old_state_next;
        new_state_reg <= new_state_next;
        new_final_reg <= new_final_next;
        if (accept)
        begin
            slot_reg <= process_slot;
            q_reg    <= q_calc;
            sym_reg  <= symbol;
        end
        if (state_reg == ST_PREAD)
        begin
            idx_reg <= idx_calc;
        end
        if (state_reg == ST_TREAD)
        begin
            cur_reg         <= cur_calc;
            range_reg       <= range_calc;
            after_final_reg <= after_final_calc;
        end
    end

    assign done      = done_reg;
    assign verdict   = verdict_reg;
    assign kill      = kill_reg;
    assign old_state = old_state_reg;
    assign new_state = new_state_reg;
    assign new_final = new_final_reg;

`ifndef SYNTHESIS
    a_quiet_clear : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !done)
        else $error("done raised while tables are being cleared");

    a_kill_match : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (kill == ((verdict == VERDICT_NO_TRANS) || (verdict == VERDICT_AFTER_FINAL))))
        else $error("kill disagrees with verdict");

    a_load_answer : assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && mode) |=> (done && (verdict == VERDICT_LOADED)))
        else $error("load word not answered next cycle");

    a_event_answer : assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !mode) |-> ##4 (done && (verdict != VERDICT_LOADED)))
        else $error("event word not answered after four cycles");
`endif

endmodule
